@@ hw/rtl/nlp_pkg.sv @@
// shared types and constants for the numeric literal parser
// no dependencies; imported by every module of the block
`default_nettype none

package nlp_pkg;

  localparam int unsigned EXP_WIDTH_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned MANT_W    = 64;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned EXP_OUT_W = 16;
  localparam int unsigned RADIX_W   = 2;

  localparam logic [RADIX_W-1:0] RX_BIN = 2'd0;
  localparam logic [RADIX_W-1:0] RX_OCT = 2'd1;
  localparam logic [RADIX_W-1:0] RX_DEC = 2'd2;
  localparam logic [RADIX_W-1:0] RX_HEX = 2'd3;

  // one classified character
  typedef struct packed {
    logic       last;
    logic       is_dig;
    logic [3:0] dig;
    logic       quote;
    logic       dot;
    logic       ch_x;
    logic       ch_b;
    logic       ch_p;
    logic       ch_e;
    logic       plus;
    logic       minus;
  } tok_t;

  // one parsed literal
  typedef struct packed {
    logic                 is_real;
    logic [RADIX_W-1:0]   radix;
    logic [MANT_W-1:0]    mantissa;
    logic [FRAC_W-1:0]    frac;
    logic [EXP_OUT_W-1:0] expo;
    logic                 exp_neg;
    logic                 exp_b2;
    logic                 ovf;
    logic                 err;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/nlp_front.sv @@
// front end: takes characters and classifies them into tokens for the queue
// depends on nlp_pkg
`default_nettype none

module nlp_front (
  input  wire  logic        in_valid_i,
  output       logic        in_ready_o,
  input  wire  logic [7:0]  character_i,
  input  wire  logic        last_char_i,
  input  wire  logic        full_i,
  output       logic        push_o,
  output       nlp_pkg::tok_t tok_o
);
  import nlp_pkg::*;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] OFS_LA   = 8'h57;
  localparam logic [7:0] OFS_UA   = 8'h37;

  logic       dec_dig, low_hex, up_hex;
  logic [7:0] diff;

  assign dec_dig = (character_i >= CH_0)  && (character_i <= CH_9);
  assign low_hex = (character_i >= CH_LA) && (character_i <= CH_LF);
  assign up_hex  = (character_i >= CH_UA) && (character_i <= CH_UF);

  always_comb begin
    if (low_hex) begin
      diff = character_i - OFS_LA;
    end else if (up_hex) begin
      diff = character_i - OFS_UA;
    end else begin
      diff = character_i - CH_0;
    end
  end

  always_comb begin
    tok_o.last   = last_char_i;
    tok_o.is_dig = dec_dig || low_hex || up_hex;
    tok_o.dig    = diff[3:0];
    tok_o.quote  = (character_i == CH_QUOTE);
    tok_o.dot    = (character_i == CH_DOT);
    tok_o.ch_x   = (character_i == CH_LX) || (character_i == CH_UX);
    tok_o.ch_b   = (character_i == CH_LB) || (character_i == CH_UB);
    tok_o.ch_p   = (character_i == CH_LP) || (character_i == CH_UP);
    tok_o.ch_e   = (character_i == CH_LE) || (character_i == CH_UE);
    tok_o.plus   = (character_i == CH_PLUS);
    tok_o.minus  = (character_i == CH_MINUS);
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

@@ hw/rtl/nlp_fifo.sv @@
// short token queue between the front end and the back end
// depends on nlp_pkg
`default_nettype none

module nlp_fifo #(
  parameter int unsigned DEPTH = nlp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          push_i,
  input  wire  nlp_pkg::tok_t data_i,
  output       logic          full_o,
  input  wire  logic          pop_i,
  output       logic          valid_o,
  output       nlp_pkg::tok_t data_o
);
  import nlp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tok_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nlp_back.sv @@
// back end: parser state, digit accumulators and result register
// depends on nlp_pkg
`default_nettype none

module nlp_back #(
  parameter int unsigned EXP_WIDTH = nlp_pkg::EXP_WIDTH_DEF
) (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          tok_valid_i,
  input  wire  nlp_pkg::tok_t tok_i,
  output       logic          pop_o,
  output       logic          out_valid_o,
  input  wire  logic          out_ready_i,
  output       nlp_pkg::res_t res_o
);
  import nlp_pkg::*;

  localparam int unsigned EXP_W = (EXP_WIDTH >= EXP_OUT_W) ? EXP_OUT_W : EXP_WIDTH;
  localparam int unsigned EW4   = EXP_W + 4;
  localparam int unsigned WW    = MANT_W + 4;
  localparam logic [EXP_W-1:0] EXP_CAP = {EXP_W{1'b1}};

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ZERO  = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_FRAC  = 3'd3;
  localparam logic [2:0] PH_EXP10 = 3'd4;
  localparam logic [2:0] PH_EXP2  = 3'd5;

  logic [2:0]         ph_q, ph_d, ph_sig;
  logic [RADIX_W-1:0] rx_q, rx_d, rx_sig;
  logic [MANT_W-1:0]  val_q, val_d, alt_q, alt_d;
  logic               alt_ovf_q, alt_ovf_d, oct_bad_q, oct_bad_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [EXP_W-1:0]   exp_q, exp_d;
  logic               neg_q, neg_d, ovf_q, ovf_d, err_q, err_d;
  logic               run_sig, run_exp;
  logic [WW-1:0]      val_w, val_sum, alt_w, alt_sum;
  logic [4:0]         radix_num;
  logic [EW4-1:0]     exp_sum;
  logic               out_valid_q, take;
  res_t               res_q, res_d;

  // radix and phase in effect for a significand character
  always_comb begin
    case (ph_q)
      PH_START: begin
        rx_sig = RX_DEC;
        ph_sig = PH_INT;
      end
      PH_ZERO: begin
        rx_sig = RX_OCT;
        ph_sig = PH_INT;
      end
      default: begin
        rx_sig = rx_q;
        ph_sig = ph_q;
      end
    endcase
  end

  // accumulate steps, carry-out above 64 bits marks a wrap
  assign val_w = WW'(val_q);
  assign alt_w = WW'(alt_q);
  always_comb begin
    case (rx_sig)
      RX_BIN: begin
        val_sum   = (val_w << 1) + WW'(tok_i.dig);
        radix_num = 5'd2;
      end
      RX_OCT: begin
        val_sum   = (val_w << 3) + WW'(tok_i.dig);
        radix_num = 5'd8;
      end
      RX_DEC: begin
        val_sum   = (val_w << 3) + (val_w << 1) + WW'(tok_i.dig);
        radix_num = 5'd10;
      end
      default: begin
        val_sum   = (val_w << 4) + WW'(tok_i.dig);
        radix_num = 5'd16;
      end
    endcase
  end
  assign alt_sum = (alt_w << 3) + (alt_w << 1) + WW'(tok_i.dig);
  assign exp_sum = (EW4'(exp_q) << 3) + (EW4'(exp_q) << 1) + EW4'(tok_i.dig);

  always_comb begin
    ph_d      = ph_q;
    rx_d      = rx_q;
    val_d     = val_q;
    alt_d     = alt_q;
    alt_ovf_d = alt_ovf_q;
    oct_bad_d = oct_bad_q;
    frac_d    = frac_q;
    exp_d     = exp_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    err_d     = err_q;
    run_sig   = 1'b0;
    run_exp   = 1'b0;

    case (ph_q)
      PH_START: begin
        if (tok_i.is_dig && (tok_i.dig == 4'd0)) begin
          ph_d = PH_ZERO;
          rx_d = RX_OCT;
        end else begin
          ph_d    = PH_INT;
          rx_d    = RX_DEC;
          run_sig = 1'b1;
        end
      end
      PH_ZERO: begin
        ph_d = PH_INT;
        if (tok_i.ch_x) begin
          rx_d = RX_HEX;
        end else if (tok_i.ch_b) begin
          rx_d = RX_BIN;
        end else begin
          run_sig = 1'b1;
        end
      end
      PH_INT, PH_FRAC: begin
        run_sig = 1'b1;
      end
      default: begin
        run_exp = 1'b1;
      end
    endcase

    if (run_sig) begin
      if (tok_i.quote) begin
        ph_d = ph_sig;
      end else if (tok_i.dot) begin
        if (ph_sig == PH_INT) begin
          ph_d = PH_FRAC;
          if (rx_sig == RX_OCT) begin
            rx_d  = RX_DEC;
            val_d = alt_q;
            ovf_d = alt_ovf_q;
          end
        end else begin
          err_d = 1'b1;
        end
      end else if ((rx_sig == RX_HEX) && tok_i.ch_p) begin
        ph_d = PH_EXP2;
      end else if ((rx_sig != RX_HEX) && tok_i.ch_e) begin
        ph_d = PH_EXP10;
        if (rx_sig == RX_OCT) begin
          rx_d  = RX_DEC;
          val_d = alt_q;
          ovf_d = alt_ovf_q;
        end
      end else if (rx_sig == RX_OCT) begin
        if (!tok_i.is_dig || (tok_i.dig >= 4'd10)) begin
          err_d = 1'b1;
        end else begin
          val_d     = val_sum[MANT_W-1:0];
          ovf_d     = ovf_q || (val_sum[WW-1:MANT_W] != '0);
          alt_d     = alt_sum[MANT_W-1:0];
          alt_ovf_d = alt_ovf_q || (alt_sum[WW-1:MANT_W] != '0);
          if (tok_i.dig >= 4'd8) begin
            oct_bad_d = 1'b1;
          end
        end
      end else if (!tok_i.is_dig || (5'(tok_i.dig) >= radix_num)) begin
        err_d = 1'b1;
      end else begin
        val_d = val_sum[MANT_W-1:0];
        ovf_d = ovf_q || (val_sum[WW-1:MANT_W] != '0);
        if (ph_sig == PH_FRAC) begin
          if (frac_q == {FRAC_W{1'b1}}) begin
            ovf_d = 1'b1;
          end else begin
            frac_d = frac_q + FRAC_W'(1);
          end
        end
      end
    end

    if (run_exp) begin
      if (tok_i.quote || tok_i.plus) begin
        neg_d = neg_q;
      end else if (tok_i.minus) begin
        neg_d = !neg_q;
      end else if (!tok_i.is_dig || (tok_i.dig >= 4'd10)) begin
        err_d = 1'b1;
      end else if (exp_sum > EW4'(EXP_CAP)) begin
        exp_d = EXP_CAP;
        ovf_d = 1'b1;
      end else begin
        exp_d = exp_sum[EXP_W-1:0];
      end
    end
  end

  always_comb begin
    res_d.is_real  = (ph_d == PH_FRAC) || (ph_d == PH_EXP10) || (ph_d == PH_EXP2);
    res_d.radix    = rx_d;
    res_d.mantissa = val_d;
    res_d.frac     = frac_d;
    res_d.expo     = EXP_OUT_W'(exp_d);
    res_d.exp_neg  = neg_d;
    res_d.exp_b2   = (ph_d == PH_EXP2);
    res_d.ovf      = ovf_d;
    res_d.err      = err_d || ((rx_d == RX_OCT) && oct_bad_d);
  end

  // a last character waits only while the result register is held
  assign pop_o = tok_valid_i && (!tok_i.last || !out_valid_q || out_ready_i);
  assign take  = pop_o && tok_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_START;
      rx_q        <= RX_DEC;
      val_q       <= '0;
      alt_q       <= '0;
      alt_ovf_q   <= 1'b0;
      oct_bad_q   <= 1'b0;
      frac_q      <= '0;
      exp_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (tok_i.last) begin
          ph_q      <= PH_START;
          rx_q      <= RX_DEC;
          val_q     <= '0;
          alt_q     <= '0;
          alt_ovf_q <= 1'b0;
          oct_bad_q <= 1'b0;
          frac_q    <= '0;
          exp_q     <= '0;
          neg_q     <= 1'b0;
          ovf_q     <= 1'b0;
          err_q     <= 1'b0;
        end else begin
          ph_q      <= ph_d;
          rx_q      <= rx_d;
          val_q     <= val_d;
          alt_q     <= alt_d;
          alt_ovf_q <= alt_ovf_d;
          oct_bad_q <= oct_bad_d;
          frac_q    <= frac_d;
          exp_q     <= exp_d;
          neg_q     <= neg_d;
          ovf_q     <= ovf_d;
          err_q     <= err_d;
        end
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/numeric_literal_parser.sv @@
// Numeric literal parser top level: one character per request in, one
// parsed literal out when the marked last character has been processed.
// Sustained rate is one character per clock while the queue is not full and
// no last character waits on a held result; the back end's multiply-by-radix
// accumulate is combinational. A taken character is written into the queue
// and processed by the back end once it reaches the queue head, and the
// result register is loaded when the last character is processed.
// The front end classifies characters into a QUEUE_DEPTH-entry queue; a
// result waiting in the output register stalls only the next last character,
// and input stops only once the queue is full.
// Depends on nlp_pkg, nlp_front, nlp_fifo and nlp_back.
`default_nettype none

module numeric_literal_parser #(
  parameter int unsigned EXP_WIDTH   = nlp_pkg::EXP_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = nlp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        in_valid_i,
  output       logic        in_ready_o,
  input  wire  logic [7:0]  character_i,
  input  wire  logic        last_char_i,
  output       logic        out_valid_o,
  input  wire  logic        out_ready_i,
  output       logic        is_real_o,
  output       logic [1:0]  radix_code_o,
  output       logic [63:0] mantissa_o,
  output       logic [7:0]  fraction_digits_o,
  output       logic [15:0] exponent_value_o,
  output       logic        exponent_negative_o,
  output       logic        exponent_base_two_o,
  output       logic        overflow_o,
  output       logic        error_o
);
  import nlp_pkg::*;

  tok_t tok_in, tok_out;
  logic push, full, tok_valid, pop;
  res_t res;

  nlp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .last_char_i (last_char_i),
    .full_i      (full),
    .push_o      (push),
    .tok_o       (tok_in)
  );

  nlp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (tok_valid),
    .data_o  (tok_out)
  );

  nlp_back #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign is_real_o           = res.is_real;
  assign radix_code_o        = res.radix;
  assign mantissa_o          = res.mantissa;
  assign fraction_digits_o   = res.frac;
  assign exponent_value_o    = res.expo;
  assign exponent_negative_o = res.exp_neg;
  assign exponent_base_two_o = res.exp_b2;
  assign overflow_o          = res.ovf;
  assign error_o             = res.err;

endmodule

`default_nettype wire

@@ hw/rtl/nlp_checker.sv @@
// port-level checks for the numeric literal parser, bound to the top level
// depends on nlp_pkg and numeric_literal_parser
`default_nettype none

module nlp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        is_real_o,
  input wire logic [1:0]  radix_code_o,
  input wire logic [63:0] mantissa_o,
  input wire logic [7:0]  fraction_digits_o,
  input wire logic [15:0] exponent_value_o,
  input wire logic        exponent_negative_o,
  input wire logic        exponent_base_two_o,
  input wire logic        overflow_o,
  input wire logic        error_o
);
  import nlp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mantissa_o)
      && $stable(error_o) && $stable(radix_code_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // integers carry no fraction or exponent parts
  a_int_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_real_o |-> fraction_digits_o == 8'd0
      && exponent_value_o == 16'd0 && !exponent_negative_o && !exponent_base_two_o)
    else $error("integer result with fraction or exponent");

  // a power-of-two exponent only follows a hex significand
  a_p_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exponent_base_two_o |-> radix_code_o == RX_HEX && is_real_o)
    else $error("binary exponent outside hex");

  // a point or exponent always turns octal into decimal
  a_oct_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && radix_code_o == RX_OCT |-> !is_real_o)
    else $error("octal real result");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (.*);

`default_nettype wire
